@@ rtl/neural_activation_unit_macros.svh @@
// assertion macros for the neural activation unit
`ifndef NEURAL_ACTIVATION_UNIT_MACROS_SVH
`define NEURAL_ACTIVATION_UNIT_MACROS_SVH

// same-cycle implication, checked on clk, off during rst
`define NAU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked on clk, off during rst
`define NAU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/nau_pkg.sv @@
// shared types, constants and tables of the neural activation unit
`default_nettype none

package nau_pkg;

  localparam int LAYER_MAX_DEF = 64;
  localparam int FRAC_BITS_DEF = 11;

  localparam logic [16:0] LOG2E_Q16 = 17'd94548;

  // mode register codes
  localparam logic [2:0] MODE_IDENT = 3'd0;
  localparam logic [2:0] MODE_RELU  = 3'd1;
  localparam logic [2:0] MODE_TANH  = 3'd2;
  localparam logic [2:0] MODE_SIGM  = 3'd3;
  localparam logic [2:0] MODE_SMAX  = 3'd4;

  typedef enum logic [2:0] {
    OP_IDENT,
    OP_RELU,
    OP_TANH,
    OP_SIGM,
    OP_SMAX
  } op_t;

  typedef struct packed {
    op_t                op;
    logic signed [15:0] value;
    logic               last;
  } q_entry_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_EXP,
    B_SM_READ,
    B_SM_EXP,
    B_SM_WAIT,
    B_DIV
  } back_state_t;

  typedef struct packed {
    logic pop;
    logic div_busy;
  } back_status_t;

  // 2^(i/16) in Q16
  function automatic logic [17:0] pow2_q16(input logic [4:0] idx);
    logic [17:0] v;
    unique case (idx)
      5'd0:    v = 18'd65536;
      5'd1:    v = 18'd68438;
      5'd2:    v = 18'd71468;
      5'd3:    v = 18'd74632;
      5'd4:    v = 18'd77936;
      5'd5:    v = 18'd81386;
      5'd6:    v = 18'd84990;
      5'd7:    v = 18'd88752;
      5'd8:    v = 18'd92682;
      5'd9:    v = 18'd96785;
      5'd10:   v = 18'd101070;
      5'd11:   v = 18'd105545;
      5'd12:   v = 18'd110218;
      5'd13:   v = 18'd115098;
      5'd14:   v = 18'd120194;
      5'd15:   v = 18'd125515;
      5'd16:   v = 18'd131072;
      default: v = 18'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

@@ rtl/nau_exp.sv @@
// three-stage table exponential, unsigned fixed point result saturated to 32 bits
`default_nettype none

module nau_exp #(
  parameter int FRAC_BITS = nau_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               go,
  input  wire logic signed [17:0] x,
  output logic                    done,
  output logic [31:0]             e
);
  import nau_pkg::*;

  localparam int S  = FRAC_BITS + 16;
  localparam int RW = S - 4;

  logic               v1, v2;
  logic signed [35:0] y;
  logic signed [35:0] ysh;
  logic [3:0]         idx;
  logic [17:0]        base;
  logic [12:0]        diff;
  logic [12+RW:0]     prod;
  logic signed [15:0] n2;
  logic [17:0]        mant;
  logic signed [15:0] sh;
  logic [32:0]        up;
  logic [4:0]         dn;
  logic [31:0]        e_next;

  // stage 1: scale by log2(e)
  always_ff @(posedge clk) begin
    y <= 36'(x) * $signed({19'd0, LOG2E_Q16});
  end

  assign ysh  = y >>> S;
  assign idx  = y[S-1:S-4];
  assign diff = 13'(pow2_q16(5'(idx) + 5'd1) - pow2_q16(5'(idx)));

  // stage 2: table lookup and interpolation product
  always_ff @(posedge clk) begin
    n2   <= ysh[15:0];
    base <= pow2_q16(5'(idx));
    prod <= (13+RW)'(diff) * (13+RW)'(y[RW-1:0]);
  end

  // stage 3: shift into output format and saturate
  always_comb begin
    mant   = base + 18'(prod >> RW);
    sh     = n2 + 16'(FRAC_BITS) - 16'sd16;
    up     = 33'(mant) << sh[3:0];
    dn     = 5'(-sh);
    e_next = 32'd0;
    if (sh >= 16'sd16) begin
      e_next = '1;
    end else if (sh >= 16'sd0) begin
      e_next = up[32] ? '1 : up[31:0];
    end else if (sh > -16'sd18) begin
      e_next = 32'(mant >> dn);
    end
  end

  always_ff @(posedge clk) begin
    e <= e_next;
  end

  // valid pipe
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= go;
      v2   <= v1;
      done <= v2;
    end
  end

endmodule

`default_nettype wire

@@ rtl/nau_div.sv @@
// restoring unsigned divider, one quotient bit per cycle
`default_nettype none

module nau_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        go,
  input  wire logic [47:0] num,
  input  wire logic [32:0] den,
  output logic             busy,
  output logic             done,
  output logic [47:0]      quo
);
  import nau_pkg::*;

  logic [33:0] rem;
  logic [47:0] nsh;
  logic [32:0] dreg;
  logic [5:0]  cnt;
  logic [33:0] trial;
  logic        fits;

  assign trial = {rem[32:0], nsh[47]};
  assign fits  = trial >= {1'b0, dreg};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        cnt  <= 6'd47;
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (go) begin
      rem  <= '0;
      nsh  <= num;
      dreg <= den;
      quo  <= '0;
    end else if (busy) begin
      rem <= fits ? trial - {1'b0, dreg} : trial;
      nsh <= {nsh[46:0], 1'b0};
      quo <= {quo[46:0], fits};
    end
  end

endmodule

`default_nettype wire

@@ rtl/nau_front.sv @@
// mode register, item classification and the two-entry item queue
`default_nettype none

module nau_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic signed [15:0]  value,
  input  wire logic                last,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [2:0]          cfg_data,
  output logic                     q_valid,
  output nau_pkg::q_entry_t        q_head,
  input  wire logic                pop
);
  import nau_pkg::*;

  logic [2:0] mode;
  q_entry_t   qmem [2];
  logic       wp, rp;
  logic [1:0] fill;
  logic       push;
  q_entry_t   ent;

  assign cfg_ready = 1'b1;
  assign busy      = fill == 2'd2;
  assign push      = start && !busy;
  assign q_valid   = fill != 2'd0;
  assign q_head    = qmem[rp];

  // mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_IDENT;
    end else if (cfg_valid && cfg_ready) begin
      mode <= cfg_data;
    end
  end

  // classify the item by mode
  always_comb begin
    ent.value = value;
    ent.last  = last;
    unique case (mode)
      MODE_RELU: ent.op = OP_RELU;
      MODE_TANH: ent.op = OP_TANH;
      MODE_SIGM: ent.op = OP_SIGM;
      MODE_SMAX: ent.op = OP_SMAX;
      default:   ent.op = OP_IDENT;
    endcase
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      qmem[wp] <= ent;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= '0;
    end else begin
      if (push) wp <= !wp;
      if (pop) rp <= !rp;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

endmodule

`default_nettype wire

@@ rtl/nau_back.sv @@
// execution side: activation sequencer, softmax layer store, exp and divider units
`default_nettype none

module nau_back #(
  parameter int LAYER_MAX = nau_pkg::LAYER_MAX_DEF,
  parameter int FRAC_BITS = nau_pkg::FRAC_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                q_valid,
  input  nau_pkg::q_entry_t        q_head,
  output nau_pkg::back_status_t    status,
  output logic signed [15:0]       result,
  output logic                     last_out,
  output logic                     strobe
);
  import nau_pkg::*;

  localparam int AW = $clog2(LAYER_MAX);
  localparam int CW = $clog2(LAYER_MAX + 1);
  localparam logic [32:0] ONE = 33'd1 << FRAC_BITS;

  back_state_t        state, state_next;
  logic               pop, exp_go, div_go;
  logic signed [17:0] exp_x;
  logic               exp_done;
  logic [31:0]        exp_e;
  logic               div_busy, div_done;
  logic [47:0]        div_num, div_quo;
  logic [32:0]        div_den;

  op_t                op_r;
  logic               last_r;
  logic               neg_r;
  logic [CW-1:0]      cnt;
  logic [AW-1:0]      idx;
  logic [31:0]        total;
  logic [15:0]        mem_q;
  logic [15:0]        store [LAYER_MAX];

  logic signed [17:0] vx, ax;
  logic [31:0]        e_cl;
  logic [32:0]        sum;
  logic               idx_last;
  logic               layer_end;

  assign vx       = 18'(q_head.value);
  assign ax       = q_head.value[15] ? -vx : vx;
  assign e_cl     = (33'(exp_e) > ONE) ? ONE[31:0] : exp_e;
  assign sum      = {1'b0, total} + {1'b0, exp_e};
  assign idx_last = (CW'(idx) + CW'(1)) == cnt;
  assign layer_end = last_r || (cnt == CW'(LAYER_MAX));

  assign status.pop      = pop;
  assign status.div_busy = div_busy;

  nau_exp #(.FRAC_BITS(FRAC_BITS)) u_exp (
    .clk  (clk),
    .rst  (rst),
    .go   (exp_go),
    .x    (exp_x),
    .done (exp_done),
    .e    (exp_e)
  );

  nau_div u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (div_go),
    .num  (div_num),
    .den  (div_den),
    .busy (div_busy),
    .done (div_done),
    .quo  (div_quo)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (q_valid && q_head.op != OP_IDENT && q_head.op != OP_RELU) state_next = B_EXP;
      end
      B_EXP: begin
        if (exp_done) begin
          if (op_r != OP_SMAX) state_next = B_DIV;
          else if (layer_end) state_next = B_SM_READ;
          else state_next = B_IDLE;
        end
      end
      B_SM_READ: state_next = B_SM_EXP;
      B_SM_EXP:  state_next = B_SM_WAIT;
      B_SM_WAIT: if (exp_done) state_next = B_DIV;
      B_DIV: begin
        if (div_done) begin
          state_next = (op_r == OP_SMAX && !idx_last) ? B_SM_READ : B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // unit launches and operands
  always_comb begin
    pop     = 1'b0;
    exp_go  = 1'b0;
    exp_x   = vx;
    div_go  = 1'b0;
    div_num = 48'(ONE - 33'(e_cl)) << FRAC_BITS;
    div_den = ONE + 33'(e_cl);
    unique case (state)
      B_IDLE: begin
        pop = q_valid;
        unique case (q_head.op)
          OP_TANH: exp_x = -(ax <<< 1);
          OP_SIGM: exp_x = -vx;
          default: exp_x = vx;
        endcase
        exp_go = q_valid && q_head.op != OP_IDENT && q_head.op != OP_RELU;
      end
      B_EXP: begin
        div_go = exp_done && op_r != OP_SMAX;
        if (op_r == OP_SIGM) begin
          div_num = 48'd1 << (2 * FRAC_BITS);
          div_den = ONE + 33'(exp_e);
        end
      end
      B_SM_EXP: begin
        exp_x  = 18'($signed(mem_q));
        exp_go = 1'b1;
      end
      B_SM_WAIT: begin
        div_go  = exp_done;
        div_num = 48'(exp_e) << FRAC_BITS;
        div_den = {1'b0, total};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else state <= state_next;
  end

  // layer store
  always_ff @(posedge clk) begin
    if (pop && q_head.op == OP_SMAX) store[cnt[AW-1:0]] <= q_head.value;
    if (state == B_SM_READ) mem_q <= store[idx];
  end

  // item latch
  always_ff @(posedge clk) begin
    if (pop) begin
      op_r   <= q_head.op;
      last_r <= q_head.last;
    end
  end

  // softmax count, index and running total
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt   <= '0;
      idx   <= '0;
      total <= '0;
    end else begin
      if (pop && q_head.op == OP_SMAX) cnt <= cnt + CW'(1);
      if (state == B_EXP && exp_done && op_r == OP_SMAX) begin
        total <= sum[32] ? '1 : sum[31:0];
        idx   <= '0;
      end
      if (state == B_DIV && div_done && op_r == OP_SMAX) begin
        if (idx_last) begin
          cnt   <= '0;
          total <= '0;
        end else begin
          idx <= idx + AW'(1);
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= (pop && (q_head.op == OP_IDENT || q_head.op == OP_RELU)) ||
                (state == B_DIV && div_done);
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_head.op == OP_IDENT) begin
      result   <= q_head.value;
      last_out <= q_head.last;
    end else if (pop && q_head.op == OP_RELU) begin
      result   <= q_head.value[15] ? 16'sd0 : q_head.value;
      last_out <= q_head.last;
    end else if (state == B_DIV && div_done) begin
      unique case (op_r)
        OP_TANH: begin
          result   <= neg_r ? -$signed(div_quo[15:0]) : $signed(div_quo[15:0]);
          last_out <= last_r;
        end
        OP_SMAX: begin
          if (total == 32'd0) result <= 16'sd0;
          else if (div_quo[47:15] != '0) result <= 16'sd32767;
          else result <= $signed(div_quo[15:0]);
          last_out <= idx_last;
        end
        default: begin
          result   <= $signed(div_quo[15:0]);
          last_out <= last_r;
        end
      endcase
    end
  end

  // sign of the tanh argument
  always_ff @(posedge clk) begin
    if (pop) neg_r <= q_head.value[15];
  end

endmodule

`default_nettype wire

@@ rtl/neural_activation_unit.sv @@
// Neural activation unit: identity, ReLU, tanh, sigmoid or layer softmax on Q fixed point.
// Items are taken with start while busy is low; busy rises only when the two-entry item
// queue is full. Identity and ReLU results are registered as the item leaves the queue.
// Tanh and sigmoid use the table exponential, then the divider at one quotient bit per
// cycle. A softmax item is stored and its exponential summed; on the item marked last, or
// when LAYER_MAX values are held, every stored value is emitted in order as its exponential
// over the sum. Results appear for one cycle on result and last_out with strobe high; the
// receiver cannot stall, so no result is ever held back. The mode register is to be
// written over cfg while the unit is idle; the user must ensure this, the block does not.
`default_nettype none

`include "neural_activation_unit_macros.svh"

module neural_activation_unit #(
  parameter int LAYER_MAX = nau_pkg::LAYER_MAX_DEF,
  parameter int FRAC_BITS = nau_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [15:0] value,
  input  wire logic               last,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_data,
  output logic signed [15:0]      result,
  output logic                    last_out,
  output logic                    strobe
);
  import nau_pkg::*;

  logic         q_valid;
  q_entry_t     q_head;
  back_status_t status;

  // accept and classify
  nau_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .value     (value),
    .last      (last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .pop       (status.pop)
  );

  // execute
  nau_back #(.LAYER_MAX(LAYER_MAX), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .status   (status),
    .result   (result),
    .last_out (last_out),
    .strobe   (strobe)
  );

  // checks
  `NAU_ASSERT_IMP(a_pop_has_item, status.pop, q_valid, "pop from empty queue")
  `NAU_ASSERT_NXT(a_accept_queued, start && !busy, q_valid, "accepted item not queued")
  `NAU_ASSERT_IMP(a_no_emit_mid_div, status.div_busy, !strobe, "result during division")

endmodule

`default_nettype wire

@@ sim/tb.sv @@
// testbench for the neural activation unit: modes, softmax layers and mode register
`default_nettype none

module tb;
  import nau_pkg::*;

  typedef struct {
    logic signed [15:0] value;
    logic               last;
  } item_t;

  typedef struct {
    logic signed [15:0] result;
    logic               last_out;
  } act_t;

  localparam int STORE_DEPTH = 64;
  localparam int FB = 11;
  localparam int SETTLE_CYCLES = 120;
  localparam int STALL_LIMIT = 3000;

  // 2^(i/16) in Q16
  localparam logic [17:0] POW2_TBL [0:16] = '{
    18'd65536, 18'd68438, 18'd71468, 18'd74632, 18'd77936, 18'd81386,
    18'd84990, 18'd88752, 18'd92682, 18'd96785, 18'd101070, 18'd105545,
    18'd110218, 18'd115098, 18'd120194, 18'd125515, 18'd131072};

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic signed [15:0] value;
  logic               last;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_data;
  logic signed [15:0] result;
  logic               last_out;
  logic               strobe;

  neural_activation_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .value(value), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .result(result), .last_out(last_out), .strobe(strobe)
  );

  // activation model state
  logic [2:0]         act_mode;
  logic signed [15:0] layer_vals [STORE_DEPTH];
  logic [31:0]        exp_sum;
  int                 layer_fill;

  item_t pending_items[$];
  act_t  expected_acts[$];
  int    errors;
  int    items_sent;
  int    acts_seen;
  int    layers_done;
  int    max_gap;
  int    gap_left;
  bit    took;
  int    stall_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // table exponential of a Q.11 argument, saturating unsigned Q.11
  function automatic logic [31:0] fx_exp(input int x);
    longint y, u, r, rem, mant, v;
    int     n, idx, sh;
    y = longint'(x) * 94548;
    u = y + (longint'(512) << 27);
    n = int'(u >>> 27) - 512;
    r = u & ((longint'(1) << 27) - 1);
    idx = int'(r >>> 23);
    rem = r & ((longint'(1) << 23) - 1);
    mant = longint'(POW2_TBL[idx]) +
           ((longint'(POW2_TBL[idx + 1] - POW2_TBL[idx]) * rem) >>> 23);
    sh = n + FB - 16;
    if (sh >= 0) begin
      if (sh >= 16) return 32'hFFFF_FFFF;
      v = mant << sh;
      return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    end
    if (-sh >= 18) return 32'd0;
    return 32'(mant >>> (-sh));
  endfunction

  function automatic logic [15:0] fx_tanh(input int x);
    longint one, e, t;
    int     a, arg;
    one = longint'(1) << FB;
    a = (x < 0) ? -x : x;
    arg = -2 * a;
    if (arg < -65536) arg = -65536;
    e = longint'(fx_exp(arg));
    if (e > one) e = one;
    t = ((one - e) << FB) / (one + e);
    return (x < 0) ? 16'(-t) : 16'(t);
  endfunction

  function automatic logic [15:0] fx_sigmoid(input int x);
    longint den;
    den = (longint'(1) << FB) + longint'(fx_exp(-x));
    return 16'((longint'(1) << (2 * FB)) / den);
  endfunction

  // work out the activations caused by one accepted item
  task automatic activate(input item_t it);
    act_t   a;
    longint total, q;
    int     i;
    a.last_out = it.last;
    case (act_mode)
      MODE_RELU: a.result = (it.value < 0) ? 16'sd0 : it.value;
      MODE_TANH: a.result = fx_tanh(int'(it.value));
      MODE_SIGM: a.result = fx_sigmoid(int'(it.value));
      MODE_SMAX: begin
        if (layer_fill >= STORE_DEPTH) layer_fill = 0;
        layer_vals[layer_fill] = it.value;
        layer_fill++;
        total = longint'(exp_sum) + longint'(fx_exp(int'(it.value)));
        exp_sum = (total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
        if (it.last || layer_fill >= STORE_DEPTH) begin
          for (i = 0; i < layer_fill; i++) begin
            q = 0;
            if (exp_sum != 0)
              q = (longint'(fx_exp(int'(layer_vals[i]))) << FB) / longint'(exp_sum);
            if (q > 32767) q = 32767;
            a.result = q[15:0];
            a.last_out = (i + 1 == layer_fill);
            expected_acts.push_back(a);
          end
          layer_fill = 0;
          exp_sum = '0;
          layers_done++;
        end
        return;
      end
      default: a.result = it.value;
    endcase
    expected_acts.push_back(a);
  endtask

  task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, $signed(got),
             $signed(want), $realtime);
    errors++;
  endtask

  // item driver, inputs change on the falling edge
  always @(negedge clk) begin
    if (!rst && (!start || took)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pending_items.size() > 0) begin
        item_t it;
        it = pending_items.pop_front();
        value <= it.value;
        last <= it.last;
        start <= 1'b1;
        gap_left <= $urandom_range(0, max_gap);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: accepted items, results and register writes
  always @(posedge clk) begin
    took = 1'b0;
    if (!rst) begin
      stall_cycles++;
      if (cfg_valid && cfg_ready) begin
        act_mode = cfg_data;
        stall_cycles = 0;
      end
      if (start && !busy) begin
        item_t it;
        it.value = value;
        it.last = last;
        activate(it);
        took = 1'b1;
        items_sent++;
        stall_cycles = 0;
      end
      if (strobe) begin
        stall_cycles = 0;
        acts_seen++;
        if (expected_acts.size() == 0) begin
          report("unexpected result", result, 16'd0);
        end else begin
          act_t e;
          e = expected_acts.pop_front();
          if (result !== e.result) report("result", result, e.result);
          if (last_out !== e.last_out) report("last_out", 16'(last_out), 16'(e.last_out));
        end
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout: no progress for %0d cycles", STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic drain();
    while (pending_items.size() > 0 || start || expected_acts.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_mode(input logic [2:0] m);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_item(input logic signed [15:0] v, input logic l);
    item_t it;
    it.value = v;
    it.last = l;
    pending_items.push_back(it);
  endtask

  function automatic logic signed [15:0] rand_value();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom);
      1:       return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      default: return 16'(int'($urandom_range(0, 16384)) - 8192);
    endcase
  endfunction

  // softmax layers of random size, now and then a full store
  task automatic add_layers(input int count);
    int n, k, m;
    for (k = 0; k < count; k++) begin
      n = ($urandom_range(0, 9) == 0) ? STORE_DEPTH : $urandom_range(1, 8);
      for (m = 0; m < n; m++)
        add_item(rand_value(), (m == n - 1) ? ((n == STORE_DEPTH) ? 1'($urandom) : 1'b1)
                                            : 1'b0);
    end
  endtask

  logic [2:0] sweep [12] = '{MODE_TANH, MODE_SMAX, MODE_IDENT, MODE_RELU, MODE_SIGM, 3'd5,
                             MODE_SMAX, 3'd6, 3'd7, MODE_TANH, MODE_SIGM, MODE_SMAX};

  initial begin
    int p, k;
    rst = 1'b1;
    start = 1'b0;
    value = '0;
    last = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    act_mode = MODE_IDENT;
    exp_sum = '0;
    layer_fill = 0;
    errors = 0;
    items_sent = 0;
    acts_seen = 0;
    layers_done = 0;
    max_gap = 0;
    gap_left = 0;
    took = 1'b0;
    stall_cycles = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: field extremes in every single-value mode
    for (p = 0; p < 4; p++) begin
      set_mode(3'(p));
      add_item(16'sh7FFF, 1'b0);
      add_item(16'sh8000, 1'b1);
      add_item(16'sh0000, 1'b0);
      add_item(-16'sd1, 1'b1);
      drain();
    end
    // directed softmax: single item, zero sum, saturation, mode change mid-layer
    set_mode(MODE_SMAX);
    add_item(16'sd100, 1'b1);
    add_item(16'sh8000, 1'b0);
    add_item(16'sh8000, 1'b0);
    add_item(16'sh8000, 1'b1);
    add_item(16'sh7FFF, 1'b0);
    add_item(16'sh7FFF, 1'b1);
    add_item(16'sd2048, 1'b0);
    add_item(-16'sd2048, 1'b0);
    drain();
    set_mode(MODE_RELU);
    add_item(-16'sd5, 1'b1);
    drain();
    set_mode(MODE_SMAX);
    add_item(16'sd0, 1'b1);
    drain();

    // random phases, sweeping the mode register
    for (p = 0; p < 12; p++) begin
      set_mode(sweep[p]);
      max_gap = (p % 3 == 1) ? 0 : 14;
      if (sweep[p] == MODE_SMAX) begin
        add_layers(5);
      end else begin
        for (k = 0; k < 16; k++) add_item(rand_value(), 1'($urandom));
      end
      drain();
    end

    $display("sent %0d items, checked %0d results, %0d softmax layers", items_sent,
             acts_seen, layers_done);
    $display("modes 0 through 7 written, gaps of 0 to 14 cycles, %0d mismatches", errors);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
